@@ rtl/gbcv_pkg.sv @@
package gbcv_pkg;

	localparam int unsigned BTN_W      = 32;
	localparam int unsigned BTN_IDX_W  = 5;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned VOL_W      = 7;
	localparam int unsigned VOL_WIDE_W = VOL_W + 2;
	localparam int unsigned QUERY_W    = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned RES_W      = BTN_W + QUERY_W + VOL_W + 1;

	// button bit positions
	localparam logic [BTN_IDX_W-1:0] BIT_UP         = 5'd0;
	localparam logic [BTN_IDX_W-1:0] BIT_UP_LEFT    = 5'd1;
	localparam logic [BTN_IDX_W-1:0] BIT_LEFT       = 5'd2;
	localparam logic [BTN_IDX_W-1:0] BIT_DOWN_LEFT  = 5'd3;
	localparam logic [BTN_IDX_W-1:0] BIT_DOWN       = 5'd4;
	localparam logic [BTN_IDX_W-1:0] BIT_DOWN_RIGHT = 5'd5;
	localparam logic [BTN_IDX_W-1:0] BIT_RIGHT      = 5'd6;
	localparam logic [BTN_IDX_W-1:0] BIT_UP_RIGHT   = 5'd7;
	localparam logic [BTN_IDX_W-1:0] BIT_A          = 5'd12;
	localparam logic [BTN_IDX_W-1:0] BIT_B          = 5'd13;
	localparam logic [BTN_IDX_W-1:0] BIT_Y          = 5'd14;
	localparam logic [BTN_IDX_W-1:0] BIT_X          = 5'd15;
	localparam logic [BTN_IDX_W-1:0] BIT_VOL_UP     = 5'd16;
	localparam logic [BTN_IDX_W-1:0] BIT_VOL_DOWN   = 5'd17;
	localparam logic [BTN_IDX_W-1:0] BIT_AB         = 5'd20;
	localparam logic [BTN_IDX_W-1:0] BIT_AX         = 5'd21;
	localparam logic [BTN_IDX_W-1:0] BIT_AY         = 5'd22;
	localparam logic [BTN_IDX_W-1:0] BIT_BX         = 5'd23;
	localparam logic [BTN_IDX_W-1:0] BIT_BY         = 5'd24;
	localparam logic [BTN_IDX_W-1:0] BIT_XY         = 5'd25;

	localparam logic [VOL_W-1:0] LOW_VOLUME_LIMIT = 7'd10;
	localparam logic [VOL_W-1:0] VOLUME_AT_RESET  = 7'd20;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd250;
	localparam logic [STEP_W-1:0]     STEP_RESET     = 6'd8;
	localparam logic [VOL_W-1:0]      FLOOR_RESET    = 7'd0;
	localparam logic [VOL_W-1:0]      CEILING_RESET  = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_INTERVAL = 2'd0,
		REG_VOLUME_STEP     = 2'd1,
		REG_VOLUME_FLOOR    = 2'd2,
		REG_VOLUME_CEILING  = 2'd3
	} cfg_reg_t;

	typedef enum logic [QUERY_W-1:0] {
		QS_RELEASED       = 3'd0,
		QS_NEWLY_PRESSED  = 3'd1,
		QS_HELD           = 3'd2,
		QS_NEWLY_RELEASED = 3'd3,
		QS_MIXED          = 3'd4
	} query_state_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] repeat_interval;
		logic [STEP_W-1:0]     step;
		logic [VOL_W-1:0]      floor_lvl;
		logic [VOL_W-1:0]      ceiling_lvl;
	} vol_cfg_t;

	typedef struct packed {
		logic [VOL_W-1:0] level;
		logic             changed;
	} vol_status_t;

endpackage

@@ rtl/gbcv_map.sv @@
module gbcv_map (
	input  logic [gbcv_pkg::BTN_W-1:0] raw,
	output logic [gbcv_pkg::BTN_W-1:0] mapped
);

	function automatic logic [gbcv_pkg::BTN_W-1:0] expand_diag(
		input logic [gbcv_pkg::BTN_W-1:0]     w,
		input logic [gbcv_pkg::BTN_IDX_W-1:0] diag,
		input logic [gbcv_pkg::BTN_IDX_W-1:0] a,
		input logic [gbcv_pkg::BTN_IDX_W-1:0] b
	);
		logic [gbcv_pkg::BTN_W-1:0] r;
		r = w;
		if (w[diag] && !w[a] && !w[b]) begin
			r[a] = 1'b1;
			r[b] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [gbcv_pkg::BTN_W-1:0] pair_combo(
		input logic [gbcv_pkg::BTN_W-1:0]     w,
		input logic [gbcv_pkg::BTN_IDX_W-1:0] a,
		input logic [gbcv_pkg::BTN_IDX_W-1:0] b,
		input logic [gbcv_pkg::BTN_IDX_W-1:0] combo
	);
		logic [gbcv_pkg::BTN_W-1:0] r;
		r = w;
		if (w[a] && w[b]) begin
			r[a]     = 1'b0;
			r[b]     = 1'b0;
			r[combo] = 1'b1;
		end
		return r;
	endfunction

	logic [gbcv_pkg::BTN_W-1:0] diag_w;

	// each diagonal check sees the bits set by the ones before it
	always_comb begin
		diag_w = expand_diag(raw, gbcv_pkg::BIT_UP_LEFT, gbcv_pkg::BIT_UP, gbcv_pkg::BIT_LEFT);
		diag_w = expand_diag(diag_w, gbcv_pkg::BIT_UP_RIGHT, gbcv_pkg::BIT_UP,
			gbcv_pkg::BIT_RIGHT);
		diag_w = expand_diag(diag_w, gbcv_pkg::BIT_DOWN_LEFT, gbcv_pkg::BIT_DOWN,
			gbcv_pkg::BIT_LEFT);
		diag_w = expand_diag(diag_w, gbcv_pkg::BIT_DOWN_RIGHT, gbcv_pkg::BIT_DOWN,
			gbcv_pkg::BIT_RIGHT);
	end

	always_comb begin
		mapped = pair_combo(diag_w, gbcv_pkg::BIT_A, gbcv_pkg::BIT_B, gbcv_pkg::BIT_AB);
		mapped = pair_combo(mapped, gbcv_pkg::BIT_A, gbcv_pkg::BIT_X, gbcv_pkg::BIT_AX);
		mapped = pair_combo(mapped, gbcv_pkg::BIT_A, gbcv_pkg::BIT_Y, gbcv_pkg::BIT_AY);
		mapped = pair_combo(mapped, gbcv_pkg::BIT_B, gbcv_pkg::BIT_X, gbcv_pkg::BIT_BX);
		mapped = pair_combo(mapped, gbcv_pkg::BIT_B, gbcv_pkg::BIT_Y, gbcv_pkg::BIT_BY);
		mapped = pair_combo(mapped, gbcv_pkg::BIT_X, gbcv_pkg::BIT_Y, gbcv_pkg::BIT_XY);
	end

endmodule

@@ rtl/gbcv_query.sv @@
module gbcv_query (
	input  logic [gbcv_pkg::BTN_W-1:0] cur,
	input  logic [gbcv_pkg::BTN_W-1:0] prev,
	input  logic [gbcv_pkg::BTN_W-1:0] mask,
	output gbcv_pkg::query_state_t     state
);

	logic [gbcv_pkg::BTN_W-1:0] cs;
	logic [gbcv_pkg::BTN_W-1:0] ps;

	assign cs = mask & cur;
	assign ps = mask & prev;

	always_comb begin
		priority if (ps == '0 && cs == mask) begin
			state = gbcv_pkg::QS_NEWLY_PRESSED;
		end else if (ps == mask && cs == mask) begin
			state = gbcv_pkg::QS_HELD;
		end else if (ps == mask && cs == '0) begin
			state = gbcv_pkg::QS_NEWLY_RELEASED;
		end else if (ps == '0 && cs == '0) begin
			state = gbcv_pkg::QS_RELEASED;
		end else begin
			state = gbcv_pkg::QS_MIXED;
		end
	end

endmodule

@@ rtl/gbcv_vol.sv @@
module gbcv_vol (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  gbcv_pkg::vol_cfg_t          cfg,
	input  logic [gbcv_pkg::BTN_W-1:0]  cur,
	input  logic [gbcv_pkg::BTN_W-1:0]  prev,
	input  logic [gbcv_pkg::TICK_W-1:0] tick,
	output gbcv_pkg::vol_status_t       status
);

	// one volume action: step (halved at low volume), then clamp to floor and ceiling
	function automatic logic [gbcv_pkg::VOL_W-1:0] nudge(
		input logic [gbcv_pkg::VOL_W-1:0] vol,
		input logic                       up,
		input gbcv_pkg::vol_cfg_t         c
	);
		logic [gbcv_pkg::STEP_W-1:0]           delta;
		logic signed [gbcv_pkg::VOL_WIDE_W-1:0] v;
		delta = (vol <= gbcv_pkg::LOW_VOLUME_LIMIT) ? (c.step >> 1) : c.step;
		if (up) begin
			v = $signed({2'b00, vol}) + $signed({3'b000, delta});
		end else begin
			v = $signed({2'b00, vol}) - $signed({3'b000, delta});
		end
		if (v < $signed({2'b00, c.floor_lvl})) begin
			v = $signed({2'b00, c.floor_lvl});
		end
		if (v > $signed({2'b00, c.ceiling_lvl})) begin
			v = $signed({2'b00, c.ceiling_lvl});
		end
		return v[gbcv_pkg::VOL_W-1:0];
	endfunction

	logic [gbcv_pkg::VOL_W-1:0]  volume_q;
	logic [gbcv_pkg::TICK_W-1:0] last_up_q;
	logic [gbcv_pkg::TICK_W-1:0] last_down_q;
	logic [gbcv_pkg::TICK_W-1:0] up_elapsed;
	logic [gbcv_pkg::TICK_W-1:0] down_elapsed;
	logic [gbcv_pkg::TICK_W-1:0] interval_wide;
	logic                        up_fire;
	logic                        down_fire;
	logic [gbcv_pkg::VOL_W-1:0]  after_up;
	logic [gbcv_pkg::VOL_W-1:0]  after_down;

	assign up_elapsed    = tick - last_up_q;
	assign down_elapsed  = tick - last_down_q;
	assign interval_wide = {{(gbcv_pkg::TICK_W - gbcv_pkg::INTERVAL_W){1'b0}},
		cfg.repeat_interval};

	// press edge, or a held button whose repeat time has passed
	assign up_fire = cur[gbcv_pkg::BIT_VOL_UP] &&
		(!prev[gbcv_pkg::BIT_VOL_UP] || (up_elapsed > interval_wide));
	assign down_fire = cur[gbcv_pkg::BIT_VOL_DOWN] &&
		(!prev[gbcv_pkg::BIT_VOL_DOWN] || (down_elapsed > interval_wide));

	assign after_up   = up_fire ? nudge(volume_q, 1'b1, cfg) : volume_q;
	assign after_down = down_fire ? nudge(after_up, 1'b0, cfg) : after_up;

	assign status.level   = after_down;
	assign status.changed = up_fire | down_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q    <= gbcv_pkg::VOLUME_AT_RESET;
			last_up_q   <= '0;
			last_down_q <= '0;
		end else if (advance) begin
			volume_q <= after_down;
			if (up_fire) begin
				last_up_q <= tick;
			end
			if (down_fire) begin
				last_down_q <= tick;
			end
		end
	end

endmodule

@@ rtl/gamepad_button_combo_volume_qualifier_unit.sv @@
// pipeline: an accepted input beat goes through the input register, then the result register, to the master side
// throughput: one poll per cycle while the master side takes its beats; the only loop is the
//   state update of the previous button word, the volume level and the two repeat timestamps
// reset: arst_n clears both pipeline valids, the previous word and timestamps to zero,
//   the volume to twenty and the registers to their defaults
module gamepad_button_combo_volume_qualifier_unit (
	input  logic                             clk,
	input  logic                             arst_n,

	// configuration write port
	input  logic                             cfg_we,
	input  logic [gbcv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbcv_pkg::CFG_DATA_W-1:0]  cfg_data,

	// poll input
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// raw_buttons [31:0], tick_ms [63:32], query_mask [95:64]
	input  logic [gbcv_pkg::IN_DATA_W-1:0]   s_axis_tdata,

	// poll result
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// mapped_buttons [31:0], query_state [34:32], volume_level [41:35],
	// volume_changed [42], zero [47:43]
	output logic [gbcv_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	// configuration registers
	gbcv_pkg::vol_cfg_t cfg_q;

	// input stage
	logic                        valid_s1;
	logic [gbcv_pkg::BTN_W-1:0]  raw_s1;
	logic [gbcv_pkg::TICK_W-1:0] tick_s1;
	logic [gbcv_pkg::BTN_W-1:0]  mask_s1;

	// result stage
	logic                        valid_s2;
	logic [gbcv_pkg::BTN_W-1:0]  mapped_s2;
	logic [gbcv_pkg::QUERY_W-1:0] query_s2;
	logic [gbcv_pkg::VOL_W-1:0]  level_s2;
	logic                        changed_s2;

	// poll state
	logic [gbcv_pkg::BTN_W-1:0]  prev_buttons_q;

	logic                        adv_s1;
	logic                        accept;
	logic [gbcv_pkg::BTN_W-1:0]  mapped;
	gbcv_pkg::query_state_t      qstate;
	gbcv_pkg::vol_status_t       vstat;

	// result stage frees up when empty or when its beat is taken
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_interval <= gbcv_pkg::INTERVAL_RESET;
			cfg_q.step            <= gbcv_pkg::STEP_RESET;
			cfg_q.floor_lvl       <= gbcv_pkg::FLOOR_RESET;
			cfg_q.ceiling_lvl     <= gbcv_pkg::CEILING_RESET;
		end else if (cfg_we) begin
			unique case (gbcv_pkg::cfg_reg_t'(cfg_index))
				gbcv_pkg::REG_REPEAT_INTERVAL: begin
					cfg_q.repeat_interval <= cfg_data[gbcv_pkg::INTERVAL_W-1:0];
				end
				gbcv_pkg::REG_VOLUME_STEP: begin
					cfg_q.step <= cfg_data[gbcv_pkg::STEP_W-1:0];
				end
				gbcv_pkg::REG_VOLUME_FLOOR: begin
					cfg_q.floor_lvl <= cfg_data[gbcv_pkg::VOL_W-1:0];
				end
				gbcv_pkg::REG_VOLUME_CEILING: begin
					cfg_q.ceiling_lvl <= cfg_data[gbcv_pkg::VOL_W-1:0];
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1  <= s_axis_tdata[gbcv_pkg::BTN_W-1:0];
			tick_s1 <= s_axis_tdata[gbcv_pkg::BTN_W +: gbcv_pkg::TICK_W];
			mask_s1 <= s_axis_tdata[gbcv_pkg::BTN_W + gbcv_pkg::TICK_W +: gbcv_pkg::BTN_W];
		end
	end

	// diagonal expansion and face-button combos
	gbcv_map u_map (
		.raw    (raw_s1),
		.mapped (mapped)
	);

	// masked press classification against the previous mapped word
	gbcv_query u_query (
		.cur   (mapped),
		.prev  (prev_buttons_q),
		.mask  (mask_s1),
		.state (qstate)
	);

	// volume buttons with repeat timing; state moves only when a beat advances
	gbcv_vol u_vol (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv_s1),
		.cfg     (cfg_q),
		.cur     (mapped),
		.prev    (prev_buttons_q),
		.tick    (tick_s1),
		.status  (vstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= '0;
		end else if (adv_s1) begin
			prev_buttons_q <= mapped;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mapped_s2  <= mapped;
			query_s2   <= qstate;
			level_s2   <= vstat.level;
			changed_s2 <= vstat.changed;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(gbcv_pkg::OUT_DATA_W - gbcv_pkg::RES_W){1'b0}},
		changed_s2, level_s2, query_s2, mapped_s2};

endmodule

@@ tb/sv/gamepad_button_combo_volume_qualifier_unit_test.sv @@
module gamepad_button_combo_volume_qualifier_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gbcv_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 11;
	localparam int HOLD_CYCLES   = 300;      // long receiver stall in the backpressure test
	localparam int SETTLE_CYCLES = 8;        // comfortably past the input and result registers
	localparam int RUN_LIMIT_NS  = 2_000_000;

	// result field positions inside m_axis_tdata
	localparam int STATE_LSB   = BTN_W;
	localparam int LEVEL_LSB   = BTN_W + QUERY_W;
	localparam int CHANGED_BIT = BTN_W + QUERY_W + VOL_W;

	// directions, face buttons and volume keys: the bits the mapping cares about
	localparam logic [BTN_W-1:0] ACTIVE_BITS = 32'h0003_F0FF;

	typedef struct packed {
		logic [BTN_W-1:0] mapped;
		query_state_t     state;
		logic [VOL_W-1:0] level;
		logic             changed;
	} poll_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_REPEAT_INTERVAL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// polls accepted by the block whose result beats have not come out yet
	poll_result_t expected_polls[$];
	poll_result_t want_poll;

	// predictor copy of the block's registers and state
	logic [INTERVAL_W-1:0] interval_reg = INTERVAL_RESET;
	logic [STEP_W-1:0]     vol_step_reg = STEP_RESET;
	logic [VOL_W-1:0]      floor_reg    = FLOOR_RESET;
	logic [VOL_W-1:0]      ceiling_reg  = CEILING_RESET;
	logic [BTN_W-1:0]      prev_mapped  = '0;
	logic [VOL_W-1:0]      volume       = VOLUME_AT_RESET;
	logic [TICK_W-1:0]     up_tick      = '0;
	logic [TICK_W-1:0]     down_tick    = '0;

	// random poll generator state
	logic [BTN_W-1:0]  gen_raw  = '0;
	logic [TICK_W-1:0] gen_tick = '0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req    = 0;         // bumped to ask the receiver for a long stall
	int fail_count      = 0;
	int polls_sent      = 0;
	int results_checked = 0;
	int settings_applied = 0;

	gamepad_button_combo_volume_qualifier_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// raw_buttons [31:0], tick_ms [63:32], query_mask [95:64]
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// mapped_buttons [31:0], query_state [34:32], volume_level [41:35],
		// volume_changed [42], zero [47:43]
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [BTN_W-1:0] btn(input logic [BTN_IDX_W-1:0] n);
		return 32'd1 << n;
	endfunction

	// a lone diagonal pulls in both of its directions
	function automatic logic [BTN_W-1:0] fill_diagonal(input logic [BTN_W-1:0] w,
			input logic [BTN_IDX_W-1:0] diag, input logic [BTN_IDX_W-1:0] a,
			input logic [BTN_IDX_W-1:0] b);
		if (w[diag] && !w[a] && !w[b]) begin
			w[a] = 1'b1;
			w[b] = 1'b1;
		end
		return w;
	endfunction

	// a held face pair collapses into its combo bit
	function automatic logic [BTN_W-1:0] fold_pair(input logic [BTN_W-1:0] w,
			input logic [BTN_IDX_W-1:0] a, input logic [BTN_IDX_W-1:0] b,
			input logic [BTN_IDX_W-1:0] combo);
		if (w[a] && w[b]) begin
			w[a]     = 1'b0;
			w[b]     = 1'b0;
			w[combo] = 1'b1;
		end
		return w;
	endfunction

	// sum taken in a wide int so it clamps instead of wrapping
	function automatic logic [VOL_W-1:0] stepped_volume(input logic [VOL_W-1:0] lvl,
			input logic up);
		int delta;
		int v;
		delta = (lvl <= LOW_VOLUME_LIMIT) ? int'(vol_step_reg >> 1) : int'(vol_step_reg);
		v = int'(lvl) + (up ? delta : -delta);
		if (v < int'(floor_reg))
			v = int'(floor_reg);
		if (v > int'(ceiling_reg))
			v = int'(ceiling_reg);
		return v[VOL_W-1:0];
	endfunction

	// press edge, or held past the repeat interval (wrapping tick difference)
	function automatic logic repeat_due(input logic now_down, input logic was_down,
			input logic [TICK_W-1:0] tick, input logic [TICK_W-1:0] last);
		logic [TICK_W-1:0] elapsed;
		elapsed = tick - last;
		if (!now_down)
			return 1'b0;
		if (!was_down)
			return 1'b1;
		return elapsed > TICK_W'(interval_reg);
	endfunction

	// works out one poll's result and advances the predictor state
	function automatic poll_result_t predict_poll(input logic [BTN_W-1:0] raw,
			input logic [TICK_W-1:0] tick, input logic [BTN_W-1:0] mask);
		logic [BTN_W-1:0] w;
		logic [BTN_W-1:0] cur_sel;
		logic [BTN_W-1:0] prev_sel;
		poll_result_t r;
		w = fill_diagonal(raw, BIT_UP_LEFT, BIT_UP, BIT_LEFT);
		w = fill_diagonal(w, BIT_UP_RIGHT, BIT_UP, BIT_RIGHT);
		w = fill_diagonal(w, BIT_DOWN_LEFT, BIT_DOWN, BIT_LEFT);
		w = fill_diagonal(w, BIT_DOWN_RIGHT, BIT_DOWN, BIT_RIGHT);
		w = fold_pair(w, BIT_A, BIT_B, BIT_AB);
		w = fold_pair(w, BIT_A, BIT_X, BIT_AX);
		w = fold_pair(w, BIT_A, BIT_Y, BIT_AY);
		w = fold_pair(w, BIT_B, BIT_X, BIT_BX);
		w = fold_pair(w, BIT_B, BIT_Y, BIT_BY);
		w = fold_pair(w, BIT_X, BIT_Y, BIT_XY);
		r.changed = 1'b0;
		if (repeat_due(w[BIT_VOL_UP], prev_mapped[BIT_VOL_UP], tick, up_tick)) begin
			up_tick   = tick;
			volume    = stepped_volume(volume, 1'b1);
			r.changed = 1'b1;
		end
		if (repeat_due(w[BIT_VOL_DOWN], prev_mapped[BIT_VOL_DOWN], tick, down_tick)) begin
			down_tick = tick;
			volume    = stepped_volume(volume, 1'b0);
			r.changed = 1'b1;
		end
		cur_sel  = mask & w;
		prev_sel = mask & prev_mapped;
		if (prev_sel == '0 && cur_sel == mask)
			r.state = QS_NEWLY_PRESSED;
		else if (prev_sel == mask && cur_sel == mask)
			r.state = QS_HELD;
		else if (prev_sel == mask && cur_sel == '0)
			r.state = QS_NEWLY_RELEASED;
		else if (prev_sel == '0 && cur_sel == '0)
			r.state = QS_RELEASED;
		else
			r.state = QS_MIXED;
		prev_mapped = w;
		r.mapped = w;
		r.level  = volume;
		return r;
	endfunction

	// offers one poll, with random idle cycles ahead of it, and records its result
	task automatic send_poll(input logic [BTN_W-1:0] raw, input logic [TICK_W-1:0] tick,
			input logic [BTN_W-1:0] mask);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom, $urandom};
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {mask, tick, raw};
		// ready is looked at mid-cycle, the beat lands on the next rising edge
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		expected_polls.push_back(predict_poll(raw, tick, mask));
		polls_sent++;
	endtask

	// stops offering and waits for every outstanding result beat
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_polls.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all four registers on consecutive edges, junk in the unused data bits
	task automatic apply_setting(input logic [INTERVAL_W-1:0] interval,
			input logic [STEP_W-1:0] vstep, input logic [VOL_W-1:0] lo,
			input logic [VOL_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_REPEAT_INTERVAL;
		cfg_data  <= interval;
		@(posedge clk);
		cfg_index <= REG_VOLUME_STEP;
		cfg_data  <= {10'($urandom), vstep};
		@(posedge clk);
		cfg_index <= REG_VOLUME_FLOOR;
		cfg_data  <= {9'($urandom), lo};
		@(posedge clk);
		cfg_index <= REG_VOLUME_CEILING;
		cfg_data  <= {9'($urandom), hi};
		@(posedge clk);
		cfg_we <= 1'b0;
		interval_reg = interval;
		vol_step_reg = vstep;
		floor_reg    = lo;
		ceiling_reg  = hi;
		settings_applied++;
	endtask

	// mostly plausible pad activity: held buttons, volume keys, ticks around the interval
	task automatic random_poll(output logic [BTN_W-1:0] raw, output logic [TICK_W-1:0] tick,
			output logic [BTN_W-1:0] mask);
		int unsigned span;
		span = 32'(interval_reg);
		case ($urandom_range(0, 6))
			0: gen_raw = $urandom;
			1, 2: ;
			3: gen_raw[BIT_VOL_DOWN:BIT_VOL_UP] = 2'($urandom);
			default: gen_raw = ($urandom & $urandom & ACTIVE_BITS)
				| ($urandom & $urandom & $urandom & ~ACTIVE_BITS);
		endcase
		case ($urandom_range(0, 5))
			0: ;
			1: gen_tick += span;
			2: gen_tick += span + 1;
			3: gen_tick += $urandom_range(0, 3 * span + 3);
			4: gen_tick = $urandom;
			default: gen_tick += $urandom_range(1, 40);
		endcase
		case ($urandom_range(0, 6))
			0: mask = $urandom;
			1: mask = btn(BTN_IDX_W'($urandom_range(0, 31)));
			2: mask = '0;
			3: mask = prev_mapped;
			4: mask = prev_mapped & $urandom;
			5: mask = gen_raw & ACTIVE_BITS;
			default: mask = '1;
		endcase
		raw  = gen_raw;
		tick = gen_tick;
	endtask

	// result checker: a beat seen valid and ready mid-cycle is taken on the next edge
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_polls.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time,
					m_axis_tdata);
				fail_count++;
			end else begin
				want_poll = expected_polls.pop_front();
				results_checked++;
				if (m_axis_tdata[BTN_W-1:0] !== want_poll.mapped) begin
					$display("%0t: mapped_buttons expected %h actual %h", $time,
						want_poll.mapped, m_axis_tdata[BTN_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[STATE_LSB +: QUERY_W] !== want_poll.state) begin
					$display("%0t: query_state expected %0d actual %0d", $time,
						want_poll.state, m_axis_tdata[STATE_LSB +: QUERY_W]);
					fail_count++;
				end
				if (m_axis_tdata[LEVEL_LSB +: VOL_W] !== want_poll.level) begin
					$display("%0t: volume_level expected %0d actual %0d", $time,
						want_poll.level, m_axis_tdata[LEVEL_LSB +: VOL_W]);
					fail_count++;
				end
				if (m_axis_tdata[CHANGED_BIT] !== want_poll.changed) begin
					$display("%0t: volume_changed expected %b actual %b", $time,
						want_poll.changed, m_axis_tdata[CHANGED_BIT]);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long counted hold-off on request
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// mapping corners, every combo, volume edges and repeats, tick wrap, query states
	task automatic test_directed_polls();
		tx_idle_pct = 20;
		rx_idle_pct <= 47;
		// empty mask reads as newly pressed
		send_poll('0, '0, '0);
		// everything pressed: both volume keys fire on their press edge
		send_poll('1, '1, '1);
		// held across a tick wrap, only one tick elapsed
		send_poll('1, '0, '1);
		send_poll('0, 32'd300, '1);
		// each diagonal alone
		send_poll(btn(BIT_UP_LEFT), 32'd400, btn(BIT_UP) | btn(BIT_LEFT));
		send_poll(btn(BIT_UP_RIGHT), 32'd401, btn(BIT_UP_RIGHT));
		send_poll(btn(BIT_DOWN_LEFT), 32'd402, btn(BIT_UP));
		send_poll(btn(BIT_DOWN_RIGHT), 32'd403, btn(BIT_DOWN));
		// second diagonal sees the directions set by the first
		send_poll(btn(BIT_UP_LEFT) | btn(BIT_UP_RIGHT), 32'd404, btn(BIT_DOWN) | btn(BIT_UP));
		send_poll(btn(BIT_DOWN_LEFT) | btn(BIT_LEFT), 32'd405, '0);
		// every face pair, then overlapping pairs where order decides
		send_poll(btn(BIT_A) | btn(BIT_B), 32'd406, btn(BIT_AB));
		send_poll(btn(BIT_A) | btn(BIT_X), 32'd407, btn(BIT_A) | btn(BIT_B));
		send_poll(btn(BIT_A) | btn(BIT_Y), 32'd408, btn(BIT_AY));
		send_poll(btn(BIT_B) | btn(BIT_X), 32'd409, btn(BIT_AY));
		send_poll(btn(BIT_B) | btn(BIT_Y), 32'd410, btn(BIT_BY) | btn(BIT_BX));
		send_poll(btn(BIT_X) | btn(BIT_Y), 32'd411, btn(BIT_XY));
		send_poll(btn(BIT_A) | btn(BIT_B) | btn(BIT_X) | btn(BIT_Y), 32'd412,
			btn(BIT_AB) | btn(BIT_XY));
		send_poll(btn(BIT_A) | btn(BIT_B) | btn(BIT_X), 32'd413, btn(BIT_X));
		// volume up: press, held exactly the interval, held one past it
		send_poll(btn(BIT_VOL_UP), 32'd1000, btn(BIT_VOL_UP));
		send_poll(btn(BIT_VOL_UP), 32'd1250, btn(BIT_VOL_UP));
		send_poll(btn(BIT_VOL_UP), 32'd1251, btn(BIT_VOL_UP));
		// volume down: press, long wrapped gap, short wrapped gap
		send_poll(btn(BIT_VOL_DOWN), 32'd5, btn(BIT_VOL_DOWN));
		send_poll(btn(BIT_VOL_DOWN), 32'hFFFF_FFF0, btn(BIT_VOL_DOWN));
		send_poll(btn(BIT_VOL_DOWN), 32'h0000_0005, btn(BIT_VOL_UP));
		// both keys: up on its edge, down on repeat
		send_poll(btn(BIT_VOL_UP) | btn(BIT_VOL_DOWN) | btn(BIT_A), 32'h0000_0200,
			btn(BIT_VOL_UP) | btn(BIT_A));
		wait_for_results();
	endtask

	// register extremes: zero and full intervals and steps, floor above ceiling
	task automatic test_register_sweep();
		logic [INTERVAL_W-1:0] intervals [8] = '{16'd0, 16'd65535, 16'd3, 16'd10,
			16'd100, 16'd20, 16'd1, 16'd250};
		logic [STEP_W-1:0] steps [8] = '{6'd63, 6'd1, 6'd0, 6'd63, 6'd17, 6'd5, 6'd2, 6'd8};
		logic [VOL_W-1:0] floors [8] = '{7'd0, 7'd0, 7'd50, 7'd127, 7'd127, 7'd0, 7'd5, 7'd0};
		logic [VOL_W-1:0] ceilings [8] = '{7'd127, 7'd127, 7'd60, 7'd0, 7'd127, 7'd0, 7'd12,
			7'd100};
		logic [BTN_W-1:0] raw;
		logic [TICK_W-1:0] tick;
		logic [BTN_W-1:0] mask;
		tx_idle_pct = 20;
		rx_idle_pct <= 47;
		for (int i = 0; i < 8; i++) begin
			apply_setting(intervals[i], steps[i], floors[i], ceilings[i]);
			repeat (45) begin
				random_poll(raw, tick, mask);
				send_poll(raw, tick, mask);
			end
			wait_for_results();
		end
	endtask

	task automatic test_random_polls(input int tx_pct, input int rx_pct, input int count);
		logic [BTN_W-1:0] raw;
		logic [TICK_W-1:0] tick;
		logic [BTN_W-1:0] mask;
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		apply_setting(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)),
			6'($urandom), 7'($urandom_range(0, 40)), 7'($urandom_range(60, 127)));
		repeat (count) begin
			random_poll(raw, tick, mask);
			send_poll(raw, tick, mask);
		end
		wait_for_results();
	endtask

	// receiver stalls long enough for the pipeline to fill and push back on input
	task automatic test_output_backpressure();
		logic [BTN_W-1:0] raw;
		logic [TICK_W-1:0] tick;
		logic [BTN_W-1:0] mask;
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (40) begin
			random_poll(raw, tick, mask);
			send_poll(raw, tick, mask);
		end
		// sender stays quiet until the block has emptied
		wait_for_results();
		rx_idle_pct <= 30;
		repeat (40) begin
			random_poll(raw, tick, mask);
			send_poll(raw, tick, mask);
		end
		wait_for_results();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_polls();
		test_register_sweep();
		test_random_polls(20, 47, 420);
		test_random_polls(47, 20, 420);
		test_random_polls(0, 0, 420);
		test_output_backpressure();
		$display("covered %0d polls, %0d result beats checked, %0d register settings",
			polls_sent, results_checked, settings_applied);
		$display("mapping corners, volume repeat and clamping, idle gaps both ways, long stall");
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d result beats outstanding", expected_polls.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
